>>> design/first_fit_heap_allocator_assert.svh
// Assertion macros used by the allocator design file.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Implication checked on the rising edge of clk; disabled while rst_n is low.
`define FFA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked on the rising edge of clk.
`define FFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/ffa_pkg.sv
package ffa_pkg;

    localparam int STATUS_W = 3;
    localparam int REQ_W    = 12;
    localparam int PTR_W    = 16;
    localparam int OFF_W    = 12;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOSPACE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FREED    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOTALLOC = 3'd5;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

endpackage

>>> design/ffa_hdr_ram.sv
module ffa_hdr_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/first_fit_heap_allocator.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+-------------------------------------
// request  | in_valid / in_ready   | req_type, req_bytes, payload_offset
// response | out_valid / out_ready | status, result_offset
//
// One request at a time; in_ready is low from accept until the response beat leaves.
// Allocate: reads and checks one block header after another, then writes the split headers.
// Free: walks the headers the same way, then reads the next block and writes the merged headers.
// The header RAM has one port and a registered read; the first request also writes the initial header.
// Reset clears control only; headers are written before use, no clearing pass.
`include "first_fit_heap_allocator_assert.svh"

module first_fit_heap_allocator #(
    parameter int ARENA_BYTES  = 4096,
    parameter int HEADER_BYTES = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         req_type,
    input  logic [ffa_pkg::REQ_W-1:0]    req_bytes,
    input  logic [ffa_pkg::PTR_W-1:0]    payload_offset,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ffa_pkg::STATUS_W-1:0] status,
    output logic [ffa_pkg::OFF_W-1:0]    result_offset
);

    localparam int AW = $clog2(ARENA_BYTES);
    localparam int RW = (AW > ffa_pkg::PTR_W) ? AW : ffa_pkg::PTR_W;
    localparam int CW = RW + 2;
    localparam logic [CW-1:0] ARENA_C = CW'(ARENA_BYTES);
    localparam logic [CW-1:0] HDR_C   = CW'(HEADER_BYTES);

    typedef struct packed {
        logic          free;
        logic          last;
        logic [AW-1:0] size;
        logic [AW-1:0] next;
    } hdr_t;

    localparam int HW = $bits(hdr_t);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_START = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_SPL1  = 4'd5;
    localparam logic [3:0] S_SPL2  = 4'd6;
    localparam logic [3:0] S_RDN   = 4'd7;
    localparam logic [3:0] S_CHKN  = 4'd8;
    localparam logic [3:0] S_WRC   = 4'd9;
    localparam logic [3:0] S_WRP   = 4'd10;

    logic [3:0]                   state_reg, state_next;
    logic                         chain_ready_reg, chain_ready_next;
    logic                         out_valid_reg, out_valid_next;
    logic [ffa_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [ffa_pkg::OFF_W-1:0]    off_reg, off_next;
    logic                         type_reg, type_next;
    logic [CW-1:0]                req_reg, req_next;
    logic [CW-1:0]                ptr_reg, ptr_next;
    logic [CW-1:0]                b_reg, b_next;
    logic [CW-1:0]                steps_reg, steps_next;
    logic [CW-1:0]                nb_reg, nb_next;
    logic [CW-1:0]                prev_reg, prev_next;
    logic                         has_prev_reg, has_prev_next;
    hdr_t                         cur_reg, cur_next;
    hdr_t                         prev_hdr_reg, prev_hdr_next;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_addr;
    hdr_t          mem_wdata, mem_rdata;
    logic [HW-1:0] rdata_raw;

    ffa_hdr_ram #(
        .WIDTH (HW),
        .DEPTH (ARENA_BYTES),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (rdata_raw)
    );

    assign mem_rdata = hdr_t'(rdata_raw);

    function automatic logic [CW-1:0] link_of(input hdr_t h);
        logic [CW-1:0] n;
        n = CW'(h.next);
        if (h.last || n >= ARENA_C)
        begin
            return ARENA_C;
        end
        return n;
    endfunction

    logic [CW-1:0] total, h_size, h_link, sum_c, sum_p;

    always_comb
    begin
        total  = req_reg + HDR_C;
        h_size = CW'(mem_rdata.size);
        h_link = link_of(mem_rdata);
        sum_c  = CW'(cur_reg.size) + HDR_C + h_size;
        sum_p  = CW'(prev_hdr_reg.size) + HDR_C + CW'(cur_reg.size);
    end

    always_comb
    begin
        state_next       = state_reg;
        chain_ready_next = chain_ready_reg;
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        off_next         = off_reg;
        type_next        = type_reg;
        req_next         = req_reg;
        ptr_next         = ptr_reg;
        b_next           = b_reg;
        steps_next       = steps_reg;
        nb_next          = nb_reg;
        prev_next        = prev_reg;
        has_prev_next    = has_prev_reg;
        cur_next         = cur_reg;
        prev_hdr_next    = prev_hdr_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_addr         = b_reg[AW-1:0];
        mem_wdata        = cur_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    type_next  = req_type;
                    req_next   = CW'(req_bytes);
                    ptr_next   = CW'(payload_offset);
                    state_next = chain_ready_reg ? S_START : S_INIT;
                end
            end
            S_INIT:
            begin
                mem_we           = 1'b1;
                mem_addr         = '0;
                mem_wdata.free   = 1'b1;
                mem_wdata.last   = 1'b1;
                mem_wdata.size   = AW'(ARENA_C - HDR_C);
                mem_wdata.next   = '0;
                chain_ready_next = 1'b1;
                state_next       = S_START;
            end
            S_START:
            begin
                b_next        = '0;
                steps_next    = '0;
                has_prev_next = 1'b0;
                off_next      = '0;
                state_next    = S_RD;
                if (type_reg == ffa_pkg::REQ_ALLOC && req_reg == '0)
                begin
                    status_next    = ffa_pkg::ST_ZERO;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (type_reg == ffa_pkg::REQ_FREE && ptr_reg >= ARENA_C)
                begin
                    status_next    = ffa_pkg::ST_RANGE;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_RD:
            begin
                if (b_reg >= ARENA_C || steps_reg > ARENA_C
                    || (type_reg == ffa_pkg::REQ_FREE && b_reg >= ptr_reg))
                begin
                    status_next    = (type_reg == ffa_pkg::REQ_FREE)
                                     ? ffa_pkg::ST_NOTALLOC : ffa_pkg::ST_NOSPACE;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (type_reg == ffa_pkg::REQ_ALLOC)
                begin
                    if (mem_rdata.free && (h_size == req_reg || h_size >= total))
                    begin
                        cur_next = mem_rdata;
                        nb_next  = b_reg + total;
                        if (h_size == req_reg)
                        begin
                            mem_we         = 1'b1;
                            mem_wdata      = mem_rdata;
                            mem_wdata.free = 1'b0;
                            status_next    = ffa_pkg::ST_OK;
                            off_next       = ffa_pkg::OFF_W'(b_reg + HDR_C);
                            out_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end
                        else if (b_reg + total >= ARENA_C)
                        begin
                            status_next    = ffa_pkg::ST_NOSPACE;
                            out_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_SPL1;
                        end
                    end
                    else
                    begin
                        b_next     = h_link;
                        steps_next = steps_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
                else
                begin
                    if (b_reg + HDR_C == ptr_reg)
                    begin
                        if (mem_rdata.free)
                        begin
                            status_next    = ffa_pkg::ST_FREED;
                            out_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            cur_next      = mem_rdata;
                            cur_next.free = 1'b1;
                            nb_next       = h_link;
                            state_next    = (h_link < ARENA_C) ? S_RDN : S_WRC;
                        end
                    end
                    else
                    begin
                        prev_next     = b_reg;
                        prev_hdr_next = mem_rdata;
                        has_prev_next = 1'b1;
                        b_next        = h_link;
                        steps_next    = steps_reg + 1'b1;
                        state_next    = S_RD;
                    end
                end
            end
            S_SPL1:
            begin
                mem_we         = 1'b1;
                mem_addr       = nb_reg[AW-1:0];
                mem_wdata.free = 1'b1;
                mem_wdata.last = cur_reg.last;
                mem_wdata.size = AW'(CW'(cur_reg.size) - total);
                mem_wdata.next = cur_reg.next;
                state_next     = S_SPL2;
            end
            S_SPL2:
            begin
                mem_we         = 1'b1;
                mem_wdata.free = 1'b0;
                mem_wdata.last = 1'b0;
                mem_wdata.size = AW'(req_reg);
                mem_wdata.next = nb_reg[AW-1:0];
                status_next    = ffa_pkg::ST_OK;
                off_next       = ffa_pkg::OFF_W'(b_reg + HDR_C);
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            S_RDN:
            begin
                mem_re     = 1'b1;
                mem_addr   = nb_reg[AW-1:0];
                state_next = S_CHKN;
            end
            S_CHKN:
            begin
                if (mem_rdata.free)
                begin
                    cur_next.size = AW'(sum_c);
                    cur_next.last = mem_rdata.last;
                    cur_next.next = mem_rdata.next;
                end
                state_next = S_WRC;
            end
            S_WRC:
            begin
                mem_we = 1'b1;
                if (has_prev_reg && prev_hdr_reg.free)
                begin
                    state_next = S_WRP;
                end
                else
                begin
                    status_next    = ffa_pkg::ST_OK;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_WRP:
            begin
                mem_we         = 1'b1;
                mem_addr       = prev_reg[AW-1:0];
                mem_wdata.free = prev_hdr_reg.free;
                mem_wdata.last = cur_reg.last;
                mem_wdata.size = AW'(sum_p);
                mem_wdata.next = cur_reg.next;
                status_next    = ffa_pkg::ST_OK;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            chain_ready_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            chain_ready_reg <= chain_ready_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        off_reg      <= off_next;
        type_reg     <= type_next;
        req_reg      <= req_next;
        ptr_reg      <= ptr_next;
        b_reg        <= b_next;
        steps_reg    <= steps_next;
        nb_reg       <= nb_next;
        prev_reg     <= prev_next;
        has_prev_reg <= has_prev_next;
        cur_reg      <= cur_next;
        prev_hdr_reg <= prev_hdr_next;
    end

    assign in_ready      = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign result_offset = off_reg;

    `FFA_ASSERT_IMPL(a_busy_while_out, out_valid, !in_ready, "request taken while response pending")
    `FFA_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready && !out_valid, "ready after accept")
    `FFA_ASSERT_IMPL(a_off_zero, out_valid && status != ffa_pkg::ST_OK, result_offset == '0, "offset on error")
    `FFA_ASSERT_IMPL(a_walk_ready, state_reg == S_RD, chain_ready_reg, "walk before chain setup")

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int ARENA   = 4096;
    localparam int HDR     = 16;
    localparam int IDLE_LIMIT = 200000;

    typedef struct packed {
        logic [ffa_pkg::STATUS_W-1:0] status;
        logic [ffa_pkg::OFF_W-1:0]    offset;
    } answer_t;

    typedef struct {
        bit       is_free;
        bit       is_last;
        int       size;
        int       next;
    } hdr_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic                         req_type;
    logic [ffa_pkg::REQ_W-1:0]    req_bytes;
    logic [ffa_pkg::PTR_W-1:0]    payload_offset;
    logic                         out_valid;
    logic                         out_ready;
    logic [ffa_pkg::STATUS_W-1:0] status;
    logic [ffa_pkg::OFF_W-1:0]    result_offset;

    hdr_t    heap [ARENA];
    bit      chain_set;
    answer_t answers_due [$];
    int      live_offsets [$];
    int      errors;
    int      idle_cycles;
    bit      hold_off;
    int      burst_left;

    first_fit_heap_allocator u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .req_bytes      (req_bytes),
        .payload_offset (payload_offset),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .result_offset  (result_offset)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int next_block(int b);
        if (heap[b].is_last || heap[b].next >= ARENA)
            return ARENA;
        return heap[b].next;
    endfunction

    function automatic answer_t heap_alloc(int req);
        answer_t a;
        int b;
        int steps;
        int need;
        int nb;
        a = '{status: ffa_pkg::ST_OK, offset: '0};
        b = 0;
        steps = 0;
        need = req + HDR;
        if (req == 0)
        begin
            a.status = ffa_pkg::ST_ZERO;
            return a;
        end
        while (b < ARENA && steps <= ARENA)
        begin
            if (heap[b].is_free && (heap[b].size == req || heap[b].size >= need))
                break;
            b = next_block(b);
            steps++;
        end
        if (b >= ARENA || steps > ARENA)
        begin
            a.status = ffa_pkg::ST_NOSPACE;
            return a;
        end
        if (heap[b].size == req)
            heap[b].is_free = 0;
        else
        begin
            nb = b + need;
            if (nb >= ARENA)
            begin
                a.status = ffa_pkg::ST_NOSPACE;
                return a;
            end
            heap[nb].is_free = 1;
            heap[nb].size = heap[b].size - need;
            heap[nb].is_last = heap[b].is_last;
            heap[nb].next = heap[b].next;
            heap[b].size = req;
            heap[b].is_free = 0;
            heap[b].is_last = 0;
            heap[b].next = nb;
        end
        a.offset = ffa_pkg::OFF_W'(b + HDR);
        return a;
    endfunction

    function automatic logic [ffa_pkg::STATUS_W-1:0] heap_free(int ptr);
        int b;
        int prev;
        int steps;
        int n;
        bit has_prev;
        b = 0;
        prev = 0;
        steps = 0;
        has_prev = 0;
        if (ptr >= ARENA)
            return ffa_pkg::ST_RANGE;
        while (b < ARENA && b < ptr && steps <= ARENA)
        begin
            if (b + HDR == ptr)
            begin
                if (heap[b].is_free)
                    return ffa_pkg::ST_FREED;
                heap[b].is_free = 1;
                n = next_block(b);
                if (n < ARENA && heap[n].is_free)
                begin
                    heap[b].size += HDR + heap[n].size;
                    heap[b].is_last = heap[n].is_last;
                    heap[b].next = heap[n].next;
                end
                if (has_prev && heap[prev].is_free)
                begin
                    heap[prev].size += HDR + heap[b].size;
                    heap[prev].is_last = heap[b].is_last;
                    heap[prev].next = heap[b].next;
                end
                return ffa_pkg::ST_OK;
            end
            prev = b;
            has_prev = 1;
            b = next_block(b);
            steps++;
        end
        return ffa_pkg::ST_NOTALLOC;
    endfunction

    function automatic answer_t heap_request(logic kind, int bytes, int ptr);
        answer_t a;
        if (!chain_set)
        begin
            heap[0] = '{is_free: 1, is_last: 1, size: ARENA - HDR, next: 0};
            chain_set = 1;
        end
        if (kind == ffa_pkg::REQ_ALLOC)
            a = heap_alloc(bytes);
        else
            a = '{status: heap_free(ptr), offset: '0};
        return a;
    endfunction

    task automatic send_request(logic kind, int bytes, int ptr);
        answer_t a;
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        in_valid       <= 1'b1;
        req_type       <= kind;
        req_bytes      <= ffa_pkg::REQ_W'(bytes);
        payload_offset <= ffa_pkg::PTR_W'(ptr);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        a = heap_request(kind, bytes, ptr);
        answers_due.push_back(a);
        if (kind == ffa_pkg::REQ_ALLOC && a.status == ffa_pkg::ST_OK)
            live_offsets.push_back(int'(a.offset));
    endtask

    task automatic alloc_req(int bytes);
        send_request(ffa_pkg::REQ_ALLOC, bytes, $urandom_range(0, 65535));
    endtask

    task automatic free_req(int ptr);
        send_request(ffa_pkg::REQ_FREE, $urandom_range(0, 4095), ptr);
    endtask

    task automatic free_live();
        int i;
        int p;
        if (live_offsets.size() == 0)
            return;
        i = $urandom_range(0, live_offsets.size() - 1);
        p = live_offsets[i];
        live_offsets.delete(i);
        free_req(p);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        burst_left = 0;
        while (answers_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        int p;
        free_req(HDR);
        free_req(ARENA);
        free_req(65535);
        free_req(0);
        alloc_req(0);
        alloc_req(4095);
        alloc_req(1);
        alloc_req(32);
        alloc_req(100);
        p = live_offsets[0];
        free_req(p);
        free_req(p);
        free_req(p + 1);
        free_req(ARENA - 1);
        alloc_req(1);
        alloc_req(2048);
        alloc_req(2048);
        free_req(live_offsets[live_offsets.size() - 1]);
        free_req(live_offsets[1]);
        free_req(live_offsets[2]);
        alloc_req(4080);
        live_offsets.delete();
        wait_drained();
    endtask

    task automatic test_random();
        int r;
        repeat (560)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                alloc_req($urandom_range(0, 7) == 0 ? $urandom_range(0, 4095)
                                                   : $urandom_range(1, 200));
            else if (r < 85)
                free_live();
            else if (r < 92)
                free_req($urandom_range(0, 65535));
            else
                free_req($urandom_range(0, 4095));
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1;
        repeat (20)
            alloc_req($urandom_range(1, 64));
        hold_off = 0;
        repeat (20)
            free_live();
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 7) > 2) || ($urandom_range(0, 1) == 0);
    end

    initial
    begin
        wait (hold_off);
        repeat (400)
            @(posedge clk);
        hold_off = 0;
    end

    always @(posedge clk)
    begin
        answer_t a;
        if (rst_n && out_valid && out_ready)
        begin
            if (answers_due.size() == 0)
            begin
                $error("unexpected beat: status %0d result_offset %0d", status, result_offset);
                errors++;
            end
            else
            begin
                a = answers_due.pop_front();
                if (status !== a.status)
                begin
                    $error("status: expected %0d actual %0d", a.status, status);
                    errors++;
                end
                if (result_offset !== a.offset)
                begin
                    $error("result_offset: expected %0d actual %0d", a.offset, result_offset);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        hold_off = 0;
        burst_left = 0;
        chain_set = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = ffa_pkg::REQ_ALLOC;
        req_bytes = '0;
        payload_offset = '0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        test_backpressure();
        wait_drained();
        repeat (50)
            @(posedge clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
